### hw/rtl/pdct_pkg.sv
// shared constants, types and fsm states of the pair dedup conflict table
package pdct_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W         = 32;
    localparam int PAIR_COUNT_W = 7;
    localparam int S_TDATA_W    = 2 * ID_W;
    localparam int M_FIELDS_W   = 4 + PAIR_COUNT_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } pdct_state_t;

    typedef struct packed {
        logic            start_set;
        logic [ID_W-1:0] star_id;
        logic [ID_W-1:0] field_id;
    } pdct_req_t;

    typedef struct packed {
        logic                    added;
        logic                    conflict;
        logic                    table_full;
        logic [PAIR_COUNT_W-1:0] pair_count;
        logic                    all_consistent;
    } pdct_rsp_t;

endpackage

### hw/rtl/pdct_engine.sv
// pair table memory with sequential search, append and conflict tracking
module pdct_engine
    import pdct_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    input  pdct_req_t req,
    output logic      req_ready,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    output pdct_rsp_t rsp
);

    pdct_state_t state_reg, state_next;

    logic [ID_W-1:0]  star_reg, field_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             flag_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic             same_reg;
    logic             shares_reg;

    // entry layout: field id high, star id low
    logic [2*ID_W-1:0] mem [TABLE_DEPTH];
    logic [2*ID_W-1:0] rd_data_reg;

    logic             star_hit, field_hit, hit_both;
    logic             full;
    logic             rd_en, wr_en;
    logic             added;
    logic [CNT_W-1:0] cnt_after;

    assign star_hit  = (rd_data_reg[ID_W-1:0] == star_reg);
    assign field_hit = (rd_data_reg[2*ID_W-1:ID_W] == field_reg);
    assign hit_both  = star_hit && field_hit;
    assign full      = (cnt_reg >= CNT_W'(TABLE_DEPTH));
    assign added     = !same_reg && !full;
    assign cnt_after = cnt_reg + CNT_W'(added);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg && hit_both) begin
                    state_next = ST_DONE;
                end else if (!rd_vld_reg && (rd_idx_reg == cnt_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        rsp_valid = 1'b0;
        wr_en     = 1'b0;
        case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_SCAN: rd_en     = (rd_idx_reg < cnt_reg);
            ST_DONE: begin
                rsp_valid = 1'b1;
                wr_en     = rsp_ready && added;
            end
            default: ;
        endcase
    end

    always_comb begin
        rsp.added          = added;
        rsp.conflict       = added && shares_reg;
        rsp.table_full     = !same_reg && full;
        rsp.pair_count     = PAIR_COUNT_W'(cnt_after);
        rsp.all_consistent = flag_reg && !(added && shares_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            flag_reg   <= 1'b1;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            same_reg   <= 1'b0;
            shares_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        if (req.start_set) begin
                            cnt_reg  <= '0;
                            flag_reg <= 1'b1;
                        end
                        rd_idx_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        same_reg   <= 1'b0;
                        shares_reg <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    rd_vld_reg <= rd_en;
                    if (rd_en) begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    if (rd_vld_reg) begin
                        if (hit_both) begin
                            same_reg <= 1'b1;
                        end else if (star_hit || field_hit) begin
                            shares_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (wr_en) begin
                        cnt_reg  <= cnt_after;
                        flag_reg <= flag_reg && !shares_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // pair payload, no reset needed
    always_ff @(posedge aclk) begin
        if (req_valid && req_ready) begin
            star_reg  <= req.star_id;
            field_reg <= req.field_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[ADDR_W-1:0]] <= {field_reg, star_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

endmodule

### hw/rtl/pair_dedup_conflict_table_top.sv
// top level of the pair dedup conflict table with stream ports
//
//  channel | dir | tdata bits (lsb first)                             | tuser
//  s_      | in  | star_id[31:0], field_id[63:32]                     | start_set
//  m_      | out | added, conflict, table_full, pair_count[9:3],      | -
//          |     | all_consistent[10], zero pad to 16                 |
//
// a word is compared with the stored pairs in turn, one entry read per cycle, until it
// matches one or reaches the end of the filled part of the table, and the engine takes
// the next word in the cycle after its result leaves
// synchronous reset empties the table and sets the consistent flag; memory is not cleared
// a waiting result sits in the output register while the next word is searched; the
// engine holds its own result in its done state until that register frees up
module pair_dedup_conflict_table_top
    import pdct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // star_id, field_id
    input  logic                 s_tuser,   // start_set
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // added, conflict, table_full, pair_count,
                                            // all_consistent, zero pad
);

    pdct_req_t req;
    pdct_rsp_t rsp;
    logic      rsp_valid;
    logic      rsp_ready;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    // unpack the input word
    always_comb begin
        req.start_set = s_tuser;
        req.star_id   = s_tdata[ID_W-1:0];
        req.field_id  = s_tdata[2*ID_W-1:ID_W];
    end

    pdct_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // output slot is free when empty or being drained this cycle
    assign rsp_ready = !m_valid_reg || m_tready;

    // pack the result word, lowest field first
    assign m_data_next = {
        {(M_TDATA_W - M_FIELDS_W){1'b0}},
        rsp.all_consistent,
        rsp.pair_count,
        rsp.table_full,
        rsp.conflict,
        rsp.added
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    // a conflict is only reported for a stored pair and always clears the flag
    a_conflict_implies_added: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[0] && !m_tdata[10]))
        else $error("conflict reported without append or with flag still set");

    // a dropped pair means the table is at capacity and nothing was appended
    a_full_means_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |->
        (!m_tdata[0] && (m_tdata[9:3] == PAIR_COUNT_W'(TABLE_DEPTH))))
        else $error("table_full with wrong count or with append");

    // the engine searches one pair at a time
    a_one_pair_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new pair accepted while search in progress");

    // a result leaves the engine only into a free output slot
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result overwritten");
`endif

endmodule
